### hdl/assert_macros.svh
// Assertion macros used by the url host authority parser module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define UHAP_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
`define UHAP_ASSERT_NEXT(lbl, clk, rst_n, cond, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
		else $error("assertion failed");
`else
`define UHAP_ASSERT(lbl, clk, rst_n, prop)
`define UHAP_ASSERT_NEXT(lbl, clk, rst_n, cond, expr)
`endif
`endif

### hdl/uhap_pkg.sv
// Types, state codes, status codes and character classes of the host parser.
package uhap_pkg;

	localparam int POS_W = 16;

	typedef logic [3:0] state_t;
	typedef logic [1:0] status_t;
	typedef logic [7:0] char_t;

	localparam state_t ST_USER_START = 4'd0;
	localparam state_t ST_USER       = 4'd1;
	localparam state_t ST_START      = 4'd2;
	localparam state_t ST_V6_START   = 4'd3;
	localparam state_t ST_V6         = 4'd4;
	localparam state_t ST_V6_END     = 4'd5;
	localparam state_t ST_ZONE_START = 4'd6;
	localparam state_t ST_ZONE       = 4'd7;
	localparam state_t ST_HOST       = 4'd8;
	localparam state_t ST_PORT_START = 4'd9;
	localparam state_t ST_PORT       = 4'd10;
	localparam state_t ST_DEAD       = 4'd15;

	localparam status_t STATUS_RUN    = 2'd0;
	localparam status_t STATUS_DEAD   = 2'd1;
	localparam status_t STATUS_ACCEPT = 2'd2;
	localparam status_t STATUS_BAD    = 2'd3;

	localparam char_t CH_AT      = 8'h40;
	localparam char_t CH_LBRACK  = 8'h5b;
	localparam char_t CH_RBRACK  = 8'h5d;
	localparam char_t CH_PERCENT = 8'h25;
	localparam char_t CH_COLON   = 8'h3a;

	function automatic logic is_num(char_t c);
		return c inside {[8'h30:8'h39]};
	endfunction

	function automatic logic is_alnum(char_t c);
		return c inside {[8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a]};
	endfunction

	function automatic logic is_hex(char_t c);
		return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
	endfunction

	// Letters, digits, marks and the sub-delimiters allowed in userinfo.
	function automatic logic is_user_char(char_t c);
		return is_alnum(c) || (c inside {8'h2d, 8'h5f, 8'h2e, 8'h21, 8'h7e, 8'h2a,
			8'h27, 8'h28, 8'h29, 8'h25, 8'h3b, 8'h3a, 8'h26, 8'h3d, 8'h2b,
			8'h24, 8'h2c});
	endfunction

	function automatic logic is_reg_name_char(char_t c);
		return is_alnum(c) || (c inside {8'h2e, 8'h2d, 8'h5f});
	endfunction

	function automatic logic is_zone_char(char_t c);
		return is_alnum(c) || (c inside {8'h25, 8'h2e, 8'h2d, 8'h5f, 8'h7e});
	endfunction

endpackage

### hdl/uhap_next_state.sv
// Next-state logic of the host parser for one byte.
module uhap_next_state (
	input  uhap_pkg::state_t state,
	input  uhap_pkg::char_t  ch,
	output uhap_pkg::state_t next
);
	import uhap_pkg::*;

	always_comb begin
		next = ST_DEAD;
		case (state)
			ST_USER_START, ST_USER: begin
				if (ch == CH_AT) next = ST_START;
				else if (is_user_char(ch)) next = ST_USER;
			end
			ST_START: begin
				if (ch == CH_LBRACK) next = ST_V6_START;
				else if (is_reg_name_char(ch)) next = ST_HOST;
			end
			ST_HOST: begin
				if (is_reg_name_char(ch)) next = ST_HOST;
				else if (ch == CH_COLON) next = ST_PORT_START;
			end
			ST_V6_END: begin
				if (ch == CH_COLON) next = ST_PORT_START;
			end
			ST_V6_START, ST_V6: begin
				if (state == ST_V6 && ch == CH_RBRACK) next = ST_V6_END;
				else if (is_hex(ch) || ch == CH_COLON || ch == 8'h2e) next = ST_V6;
				else if (state == ST_V6 && ch == CH_PERCENT) next = ST_ZONE_START;
			end
			ST_ZONE_START, ST_ZONE: begin
				if (state == ST_ZONE && ch == CH_RBRACK) next = ST_V6_END;
				else if (is_zone_char(ch)) next = ST_ZONE;
			end
			ST_PORT_START, ST_PORT: begin
				if (is_num(ch)) next = ST_PORT;
			end
			default: next = ST_DEAD;
		endcase
	end

endmodule

### hdl/url_host_authority_parser.sv
// An accepted input beat passes the input stage register, then the result registers.
// Throughput: one beat per cycle unless the result stalls; the state loop has one register.
// The result registers are the parser state itself, so a stalled result holds the state.
// Reset is asynchronous, active low: parser in host start, all offsets, counts and flags zero.
`include "assert_macros.svh"
module url_host_authority_parser #(
	parameter int OFFSET_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  uhap_pkg::char_t                   ch,
	input  logic [uhap_pkg::POS_W-1:0]        position,
	input  logic                              first,
	input  logic                              last,
	input  logic                              after_at,
	output logic                              out_valid,
	input  logic                              out_ready,
	output uhap_pkg::status_t                 status,
	output logic [uhap_pkg::POS_W-1:0]        host_offset,
	output logic [uhap_pkg::POS_W-1:0]        host_length,
	output logic                              port_seen,
	output logic [uhap_pkg::POS_W-1:0]        port_offset,
	output logic [uhap_pkg::POS_W-1:0]        port_length,
	output logic                              user_seen,
	output logic [uhap_pkg::POS_W-1:0]        user_offset,
	output logic [uhap_pkg::POS_W-1:0]        user_length
);
	import uhap_pkg::*;

	typedef logic [OFFSET_BITS-1:0] off_t;
	localparam off_t OFF_ONE = OFFSET_BITS'(1);

	logic         valid_s1;
	char_t        ch_s1;
	off_t         pos_s1;
	logic         first_s1;
	logic         last_s1;
	logic         after_at_s1;

	logic         out_valid_q;
	status_t      status_q;
	state_t       state_q;
	logic         dead_q;
	off_t         host_start_q;
	off_t         host_count_q;
	logic         port_flag_q;
	off_t         port_start_q;
	off_t         port_count_q;
	logic         user_flag_q;
	off_t         user_start_q;
	off_t         user_count_q;

	logic         proc;
	state_t       st_b;
	state_t       ns;
	status_t      status_d;
	state_t       state_d;
	logic         dead_d;
	off_t         host_start_d;
	off_t         host_count_d;
	logic         port_flag_d;
	off_t         port_start_d;
	off_t         port_count_d;
	logic         user_flag_d;
	off_t         user_start_d;
	off_t         user_count_d;

	assign proc     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || proc;
	assign st_b     = first_s1 ? (after_at_s1 ? ST_USER_START : ST_START) : state_q;

	uhap_next_state u_next (
		.state (st_b),
		.ch    (ch_s1),
		.next  (ns)
	);

	always_comb begin
		if (first_s1) begin
			state_d      = st_b;
			dead_d       = 1'b0;
			host_start_d = pos_s1;
			host_count_d = '0;
			port_flag_d  = 1'b0;
			port_start_d = '0;
			port_count_d = '0;
			user_flag_d  = 1'b0;
			user_start_d = '0;
			user_count_d = '0;
		end else begin
			state_d      = state_q;
			dead_d       = dead_q;
			host_start_d = host_start_q;
			host_count_d = host_count_q;
			port_flag_d  = port_flag_q;
			port_start_d = port_start_q;
			port_count_d = port_count_q;
			user_flag_d  = user_flag_q;
			user_start_d = user_start_q;
			user_count_d = user_count_q;
		end
		status_d = STATUS_RUN;
		if (dead_d) begin
			status_d = STATUS_DEAD;
		end else if (ns == ST_DEAD) begin
			dead_d   = 1'b1;
			status_d = STATUS_DEAD;
		end else begin
			case (ns)
				ST_HOST, ST_V6: begin
					if (st_b != ns) host_start_d = pos_s1;
					host_count_d = host_count_d + OFF_ONE;
				end
				ST_ZONE_START, ST_ZONE: begin
					host_count_d = host_count_d + OFF_ONE;
				end
				ST_PORT: begin
					if (st_b != ST_PORT) begin
						port_start_d = pos_s1;
						port_count_d = OFF_ONE;
						port_flag_d  = 1'b1;
					end else begin
						port_count_d = port_count_d + OFF_ONE;
					end
				end
				ST_USER: begin
					if (st_b != ST_USER) begin
						user_start_d = pos_s1;
						user_count_d = OFF_ONE;
						user_flag_d  = 1'b1;
					end else begin
						user_count_d = user_count_d + OFF_ONE;
					end
				end
				default: ;
			endcase
			state_d = ns;
			if (last_s1) begin
				status_d = (ns == ST_HOST || ns == ST_V6_END || ns == ST_PORT) ?
					STATUS_ACCEPT : STATUS_BAD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ch_s1       <= ch;
			pos_s1      <= OFFSET_BITS'(position);
			first_s1    <= first;
			last_s1     <= last;
			after_at_s1 <= after_at;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			status_q     <= STATUS_RUN;
			state_q      <= ST_START;
			dead_q       <= 1'b0;
			host_start_q <= '0;
			host_count_q <= '0;
			port_flag_q  <= 1'b0;
			port_start_q <= '0;
			port_count_q <= '0;
			user_flag_q  <= 1'b0;
			user_start_q <= '0;
			user_count_q <= '0;
		end else begin
			if (proc) begin
				out_valid_q  <= 1'b1;
				status_q     <= status_d;
				state_q      <= state_d;
				dead_q       <= dead_d;
				host_start_q <= host_start_d;
				host_count_q <= host_count_d;
				port_flag_q  <= port_flag_d;
				port_start_q <= port_start_d;
				port_count_q <= port_count_d;
				user_flag_q  <= user_flag_d;
				user_start_q <= user_start_d;
				user_count_q <= user_count_d;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign host_offset = POS_W'(host_start_q);
	assign host_length = POS_W'(host_count_q);
	assign port_seen   = port_flag_q;
	assign port_offset = POS_W'(port_start_q);
	assign port_length = POS_W'(port_count_q);
	assign user_seen   = user_flag_q;
	assign user_offset = POS_W'(user_start_q);
	assign user_length = POS_W'(user_count_q);

	`UHAP_ASSERT_NEXT(a_proc_gives_result, clk, arst_n, proc, out_valid_q)
	`UHAP_ASSERT(a_empty_stage_ready, clk, arst_n, !valid_s1 |-> in_ready)
	`UHAP_ASSERT_NEXT(a_dead_stays_dead, clk, arst_n, proc && dead_q && !first_s1,
		status_q == STATUS_DEAD)
	`UHAP_ASSERT(a_port_clear, clk, arst_n,
		!port_flag_q |-> (port_count_q == '0 && port_start_q == '0))
	`UHAP_ASSERT(a_user_clear, clk, arst_n,
		!user_flag_q |-> (user_count_q == '0 && user_start_q == '0))

endmodule

### bench/tb_url_host_authority_parser.sv
// Testbench for url_host_authority_parser with directed and random authority strings.
module tb_url_host_authority_parser;
	import uhap_pkg::*;

	localparam int HOLD_OFF_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int TAIL_CYCLES = 8;

	typedef struct packed {
		status_t          status;
		logic [POS_W-1:0] host_offset;
		logic [POS_W-1:0] host_length;
		logic             port_seen;
		logic [POS_W-1:0] port_offset;
		logic [POS_W-1:0] port_length;
		logic             user_seen;
		logic [POS_W-1:0] user_offset;
		logic [POS_W-1:0] user_length;
	} authority_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	char_t ch;
	logic [POS_W-1:0] position;
	logic first;
	logic last;
	logic after_at;
	logic out_valid;
	logic out_ready = 1'b0;
	status_t status;
	logic [POS_W-1:0] host_offset;
	logic [POS_W-1:0] host_length;
	logic port_seen;
	logic [POS_W-1:0] port_offset;
	logic [POS_W-1:0] port_length;
	logic user_seen;
	logic [POS_W-1:0] user_offset;
	logic [POS_W-1:0] user_length;

	// Predictor copy of the parser state.
	state_t model_state = ST_START;
	bit model_dead = 1'b0;
	logic [POS_W-1:0] model_host_start = '0;
	logic [POS_W-1:0] model_host_count = '0;
	bit model_port_flag = 1'b0;
	logic [POS_W-1:0] model_port_start = '0;
	logic [POS_W-1:0] model_port_count = '0;
	bit model_user_flag = 1'b0;
	logic [POS_W-1:0] model_user_start = '0;
	logic [POS_W-1:0] model_user_count = '0;

	authority_result_t expected_results[$];
	char_t authority_text[$];

	int unsigned parsed_bytes = 0;
	int unsigned sent_beats = 0;
	int unsigned results_checked = 0;
	int unsigned mismatch_count = 0;
	int unsigned status_tally[4] = '{0, 0, 0, 0};
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned hold_seq = 0;
	int unsigned hold_ack = 0;
	int unsigned hold_left = 0;
	int unsigned quiet_cycles = 0;

	url_host_authority_parser #(.OFFSET_BITS(POS_W)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.ch(ch),
		.position(position),
		.first(first),
		.last(last),
		.after_at(after_at),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.host_offset(host_offset),
		.host_length(host_length),
		.port_seen(port_seen),
		.port_offset(port_offset),
		.port_length(port_length),
		.user_seen(user_seen),
		.user_offset(user_offset),
		.user_length(user_length)
	);

	always #1 clk = ~clk;

	function automatic bit dec_digit(char_t c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit letter(char_t c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit hex_digit(char_t c);
		return dec_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	function automatic bit host_byte(char_t c);
		return dec_digit(c) || letter(c) || c == "." || c == "-" || c == "_";
	endfunction

	function automatic bit zone_byte(char_t c);
		return host_byte(c) || c == "%" || c == "~";
	endfunction

	function automatic bit user_byte(char_t c);
		case (c)
			"-", "_", ".", "!", "~", "*", "'", "(", ")", "%", ";", ":", "&", "=", "+", "$",
			",": return 1'b1;
			default: return dec_digit(c) || letter(c);
		endcase
	endfunction

	function automatic state_t advance_state(state_t s, char_t c);
		case (s)
			ST_USER_START, ST_USER: begin
				if (c == CH_AT)
					return ST_START;
				return user_byte(c) ? ST_USER : ST_DEAD;
			end
			ST_START: begin
				if (c == CH_LBRACK)
					return ST_V6_START;
				return host_byte(c) ? ST_HOST : ST_DEAD;
			end
			ST_HOST: begin
				if (host_byte(c))
					return ST_HOST;
				return (c == CH_COLON) ? ST_PORT_START : ST_DEAD;
			end
			ST_V6_END: return (c == CH_COLON) ? ST_PORT_START : ST_DEAD;
			ST_V6_START, ST_V6: begin
				if (s == ST_V6 && c == CH_RBRACK)
					return ST_V6_END;
				if (hex_digit(c) || c == CH_COLON || c == ".")
					return ST_V6;
				if (s == ST_V6 && c == CH_PERCENT)
					return ST_ZONE_START;
				return ST_DEAD;
			end
			ST_ZONE_START, ST_ZONE: begin
				if (s == ST_ZONE && c == CH_RBRACK)
					return ST_V6_END;
				return zone_byte(c) ? ST_ZONE : ST_DEAD;
			end
			ST_PORT_START, ST_PORT: return dec_digit(c) ? ST_PORT : ST_DEAD;
			default: return ST_DEAD;
		endcase
	endfunction

	task automatic predict_authority_byte(char_t c, logic [POS_W-1:0] pos, bit is_first,
		bit is_last, bit start_user);
		state_t nxt;
		authority_result_t r;
		r.status = STATUS_RUN;
		if (is_first) begin
			model_state = start_user ? ST_USER_START : ST_START;
			model_dead = 1'b0;
			model_host_start = pos;
			model_host_count = '0;
			model_port_flag = 1'b0;
			model_port_start = '0;
			model_port_count = '0;
			model_user_flag = 1'b0;
			model_user_start = '0;
			model_user_count = '0;
		end
		if (model_dead) begin
			r.status = STATUS_DEAD;
		end else begin
			parsed_bytes++;
			nxt = advance_state(model_state, c);
			if (nxt == ST_DEAD) begin
				model_dead = 1'b1;
				r.status = STATUS_DEAD;
			end else begin
				case (nxt)
					ST_HOST, ST_V6: begin
						if (model_state != nxt)
							model_host_start = pos;
						model_host_count++;
					end
					ST_ZONE_START, ST_ZONE: model_host_count++;
					ST_PORT: begin
						if (model_state != ST_PORT) begin
							model_port_start = pos;
							model_port_count = '0;
							model_port_flag = 1'b1;
						end
						model_port_count++;
					end
					ST_USER: begin
						if (model_state != ST_USER) begin
							model_user_start = pos;
							model_user_count = '0;
							model_user_flag = 1'b1;
						end
						model_user_count++;
					end
					default: ;
				endcase
				model_state = nxt;
				if (is_last)
					r.status = (nxt == ST_HOST || nxt == ST_V6_END || nxt == ST_PORT) ?
						STATUS_ACCEPT : STATUS_BAD;
			end
		end
		r.host_offset = model_host_start;
		r.host_length = model_host_count;
		r.port_seen = model_port_flag;
		r.port_offset = model_port_start;
		r.port_length = model_port_count;
		r.user_seen = model_user_flag;
		r.user_offset = model_user_start;
		r.user_length = model_user_count;
		expected_results.push_back(r);
	endtask

	function automatic void check_field(string name, logic [POS_W-1:0] want, logic [POS_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk) begin : result_check
		authority_result_t want;
		if (out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: result beat with none expected, actual status %0d", $time, status);
				mismatch_count++;
			end else begin
				want = expected_results.pop_front();
				results_checked++;
				status_tally[want.status]++;
				check_field("status", want.status, status);
				check_field("host_offset", want.host_offset, host_offset);
				check_field("host_length", want.host_length, host_length);
				check_field("port_seen", want.port_seen, port_seen);
				check_field("port_offset", want.port_offset, port_offset);
				check_field("port_length", want.port_length, port_length);
				check_field("user_seen", want.user_seen, user_seen);
				check_field("user_offset", want.user_offset, user_offset);
				check_field("user_length", want.user_length, user_length);
			end
		end
	end

	always @(posedge clk) begin
		if (hold_seq != hold_ack) begin
			hold_ack <= hold_seq;
			hold_left <= HOLD_OFF_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_beat(char_t c, logic [POS_W-1:0] pos, bit is_first, bit is_last,
		bit start_user);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		ch <= c;
		position <= pos;
		first <= is_first;
		last <= is_last;
		after_at <= start_user;
		do @(posedge clk); while (!in_ready);
		sent_beats++;
		predict_authority_byte(c, pos, is_first, is_last, start_user);
	endtask

	task automatic send_authority(logic [POS_W-1:0] base, bit start_user, bit mark_last);
		int n;
		n = authority_text.size();
		for (int i = 0; i < n; i++)
			send_beat(authority_text[i], base + POS_W'(i), i == 0, mark_last && i == n - 1,
				(i == 0) ? start_user : 1'($urandom_range(1)));
	endtask

	task automatic load_text(string s);
		authority_text = {};
		for (int i = 0; i < s.len(); i++)
			authority_text.push_back(s[i]);
	endtask

	function automatic char_t pick_char(string choices);
		return choices[$urandom_range(choices.len() - 1)];
	endfunction

	task automatic build_authority(output bit with_user);
		authority_text = {};
		with_user = ($urandom_range(99) < 40);
		if (with_user) begin
			repeat ($urandom_range(6, 0))
				authority_text.push_back(pick_char("abmzAMZ059-_.!~*'();:&=+$,%"));
			authority_text.push_back(CH_AT);
		end
		if ($urandom_range(99) < 65) begin
			repeat ($urandom_range(8, 1))
				authority_text.push_back(pick_char("abcmxyzABMXZ0189-._"));
		end else begin
			authority_text.push_back(CH_LBRACK);
			repeat ($urandom_range(8, 1))
				authority_text.push_back(pick_char("0129afAF:."));
			if ($urandom_range(99) < 40) begin
				authority_text.push_back(CH_PERCENT);
				repeat ($urandom_range(4, 1))
					authority_text.push_back(pick_char("aeZ09%.-_~"));
			end
			authority_text.push_back(CH_RBRACK);
		end
		if ($urandom_range(99) < 50) begin
			authority_text.push_back(CH_COLON);
			repeat ($urandom_range(5, 0))
				authority_text.push_back(pick_char("0123456789"));
		end
		if ($urandom_range(99) < 15)
			authority_text[$urandom_range(authority_text.size() - 1)] = char_t'($urandom_range(255));
		if ($urandom_range(99) < 10)
			repeat ($urandom_range(authority_text.size() - 1))
				void'(authority_text.pop_back());
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0);
	endtask

	task automatic set_idling(int unsigned sender_pct, int unsigned receiver_pct);
		send_idle_pct = sender_pct;
		recv_idle_pct <= receiver_pct;
	endtask

	task automatic test_directed_cases();
		send_beat("x", 16'd5, 1'b0, 1'b1, 1'b0);
		load_text("u@[1]:8");
		send_authority(16'h0000, 1'b1, 1'b1);
		load_text("[a%z]");
		send_authority(16'hfffe, 1'b0, 1'b1);
		load_text("h:");
		send_authority(16'h0100, 1'b0, 1'b1);
		send_beat(8'hff, 16'hffff, 1'b1, 1'b0, 1'b1);
		send_beat("a", 16'h0000, 1'b0, 1'b1, 1'b0);
		send_beat("a", 16'h0010, 1'b1, 1'b1, 1'b0);
		send_beat("b", 16'h0011, 1'b0, 1'b1, 1'b1);
		load_text("[]");
		send_authority(16'h0020, 1'b0, 1'b1);
		send_beat(8'h00, 16'h1234, 1'b1, 1'b1, 1'b0);
	endtask

	task automatic test_random_authorities(int unsigned target);
		int unsigned start_count;
		bit start_user;
		start_count = parsed_bytes;
		while (parsed_bytes - start_count < target) begin
			if ($urandom_range(99) < 85) begin
				build_authority(start_user);
				if ($urandom_range(99) < 10)
					start_user = ~start_user;
				send_authority(POS_W'($urandom_range(65535)), start_user, $urandom_range(99) < 95);
			end else begin
				repeat ($urandom_range(4, 1))
					send_beat(char_t'($urandom_range(255)), POS_W'($urandom_range(65535)),
						$urandom_range(99) < 30, 1'($urandom_range(1)), 1'($urandom_range(1)));
			end
		end
	endtask

	task automatic test_output_stall();
		bit start_user;
		int unsigned saved_pct;
		saved_pct = send_idle_pct;
		send_idle_pct = 0;
		hold_seq <= hold_seq + 1;
		repeat (8) begin
			build_authority(start_user);
			send_authority(POS_W'($urandom_range(65535)), start_user, 1'b1);
		end
		send_idle_pct = saved_pct;
		drain_results();
	endtask

	task automatic test_drain_pauses();
		bit start_user;
		repeat (4) begin
			build_authority(start_user);
			send_authority(POS_W'($urandom_range(65535)), start_user, 1'b1);
			drain_results();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		ch = '0;
		position = '0;
		first = 1'b0;
		last = 1'b0;
		after_at = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		set_idling(38, 86);
		test_directed_cases();
		test_random_authorities(700);
		drain_results();
		set_idling(86, 38);
		test_random_authorities(700);
		drain_results();
		set_idling(0, 0);
		test_output_stall();
		test_drain_pauses();
		test_random_authorities(600);
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_results.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, expected_results.size());
			mismatch_count++;
		end
		$display("Checked %0d result beats for %0d input beats: %0d accepted, %0d bad end, %0d dead.",
			results_checked, sent_beats, status_tally[STATUS_ACCEPT], status_tally[STATUS_BAD],
			status_tally[STATUS_DEAD]);
		$display("Covered userinfo, host names, IPv6 zones, ports, illegal bytes and a long stall.");
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
